### rtl/ramp_soak_profile_sequencer_assert.svh
// Assertion macros used by the sequencer execution module (rsps_exec).
// They sample on clk and are held off while rst_n is low.
`ifndef RAMP_SOAK_PROFILE_SEQUENCER_ASSERT_SVH
`define RAMP_SOAK_PROFILE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define RSPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication.
`define RSPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

### rtl/rsps_pkg.sv
package rsps_pkg;

    localparam int MAX_STEPS_DEF = 16;

    localparam int TEMP_W     = 13;
    localparam int THR_W      = 9;
    localparam int RATE_W     = 15;
    localparam int MIN_W      = 16;
    localparam int STEP_W     = 5;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 3;
    localparam int SEC_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // effective ramp rate, signed, holds +/-60000 deg/h
    localparam int ERATE_W = 17;
    // rate * seconds, signed
    localparam int PROD_W  = ERATE_W + SEC_W + 1;
    // magnitude of rate * seconds while the target is not yet crossed
    localparam int MAG_W   = 23;

    localparam int RAMP_DIV    = 900;
    localparam int RATE_LIMIT  = 9999;
    localparam int FAST_RATE   = 60000;
    localparam int SEC_PER_MIN = 60;

    // q = (m * RECIP_K) >> RECIP_SHIFT equals m / 900 for m below 2^25
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 33;
    localparam logic [RECIP_W-1:0] RECIP_K = 24'd9544372;

    localparam logic [SEC_W-1:0]  SEC_MAX = '1;
    localparam logic [TEMP_W-1:0] SP_MAX  = '1;

    localparam logic [TEMP_W-1:0] FIRST_RAMP_START_RST = 13'd100;
    localparam logic [THR_W-1:0]  PAUSE_THR_RST        = 9'd12;
    localparam logic [THR_W-1:0]  RESUME_THR_RST       = 9'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 3'd0,
        KIND_LOAD  = 3'd1,
        KIND_START = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_SKIP  = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_RAMP_START = 2'd0,
        CFG_PAUSE_THR        = 2'd1,
        CFG_RESUME_THR       = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_IDLE  = 2'd0,
        STATUS_RAMP  = 2'd1,
        STATUS_HOLD  = 2'd2,
        STATUS_ERROR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        HELD_KEEP = 2'd0,
        HELD_SET  = 2'd1,
        HELD_RAMP = 2'd2
    } held_op_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic [TEMP_W-1:0]        target;
        logic [MIN_W-1:0]         minutes;
    } step_entry_t;

    // update stage to scaling stage
    typedef struct packed {
        held_op_t          held_op;
        logic [TEMP_W-1:0] held_val;
        logic [TEMP_W-1:0] ramp_start;
        logic              ramp_neg;
        logic [MAG_W-1:0]  ramp_mag;
        logic              firing;
        status_t           status;
        logic [STEP_W-1:0] current_step;
        logic              finished;
        logic              soak_paused;
        logic              rejected;
    } mid_t;

endpackage

### rtl/rsps_exec.sv
`include "ramp_soak_profile_sequencer_assert.svh"

module rsps_exec
    import rsps_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_fire,
    input  logic [KIND_W-1:0]        kind,
    input  logic [TEMP_W-1:0]        measured_temp,
    input  logic                     sensor_ok,
    input  logic [SLOT_W-1:0]        slot,
    input  logic                     step_is_hold,
    input  logic signed [RATE_W-1:0] ramp_rate,
    input  logic [TEMP_W-1:0]        target_temp,
    input  logic [MIN_W-1:0]         hold_minutes,
    input  logic [STEP_W-1:0]        step_total,
    output mid_t                     mid_next
);

    localparam int IDX_W  = $clog2(MAX_STEPS);
    localparam int WIDE_W = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;

    logic                    firing_reg, firing_next;
    logic                    error_reg, error_next;
    logic [STEP_W-1:0]       step_index_reg, step_index_next;
    logic [STEP_W-1:0]       step_count_reg, step_count_next;
    logic [SEC_W-1:0]        step_sec_reg, step_sec_next;
    logic [SEC_W-1:0]        soak_sec_reg, soak_sec_next;
    logic                    pause_reg, pause_next;
    logic [TEMP_W-1:0]       prev_target_reg, prev_target_next;
    logic [TEMP_W-1:0]       first_start_reg;
    logic [THR_W-1:0]        pause_thr_reg;
    logic [THR_W-1:0]        resume_thr_reg;

    logic [MAX_STEPS-1:0]    hold_bits_reg;
    logic [TEMP_W-1:0]       slot0_target_reg;
    step_entry_t             step_mem [MAX_STEPS];
    step_entry_t             cur_entry_reg;
    step_entry_t             load_entry;

    logic                    slot_ok;
    logic                    slot_hits_next;
    logic                    mem_we;
    logic                    cur_hold;
    logic                    new_hold;
    logic [TEMP_W-1:0]       start_val;
    logic [SEC_W-1:0]        sec_inc;
    logic [SEC_W-1:0]        soak_inc;
    logic [SEC_W-1:0]        soak_goal;
    logic signed [ERATE_W-1:0] rate_eff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_abs;
    logic signed [PROD_W-1:0]  diff900;
    logic signed [TEMP_W:0]    diff;
    logic signed [TEMP_W:0]    dev;
    logic                    pause_new;
    logic                    crossed;
    logic                    do_adv;

    assign load_entry = '{rate: ramp_rate, target: target_temp, minutes: hold_minutes};
    assign cur_hold   = hold_bits_reg[IDX_W'(step_index_reg)];

    // ramp and hold arithmetic on the current step
    always_comb
    begin
        start_val = (step_index_reg == '0) ? first_start_reg : prev_target_reg;
        sec_inc   = (step_sec_reg != SEC_MAX) ? step_sec_reg + 1'b1 : step_sec_reg;

        if (cur_entry_reg.rate == '0 || cur_entry_reg.rate >= $signed(RATE_W'(RATE_LIMIT)))
        begin
            rate_eff = $signed(ERATE_W'(FAST_RATE));
        end
        else
        begin
            rate_eff = ERATE_W'(cur_entry_reg.rate);
        end

        prod     = PROD_W'(rate_eff) * $signed({1'b0, sec_inc});
        diff     = $signed({1'b0, cur_entry_reg.target}) - $signed({1'b0, start_val});
        diff900  = PROD_W'(diff) * $signed(PROD_W'(RAMP_DIV));
        crossed  = rate_eff[ERATE_W-1] ? (prod <= diff900) : (prod >= diff900);
        prod_abs = rate_eff[ERATE_W-1] ? -prod : prod;

        dev = $signed({1'b0, cur_entry_reg.target}) - $signed({1'b0, measured_temp});
        if (dev > $signed({1'b0, pause_thr_reg}))
        begin
            pause_new = 1'b1;
        end
        else if (dev <= $signed({1'b0, resume_thr_reg}))
        begin
            pause_new = 1'b0;
        end
        else
        begin
            pause_new = pause_reg;
        end
        soak_inc  = (!pause_new && soak_sec_reg != SEC_MAX) ? soak_sec_reg + 1'b1
                                                             : soak_sec_reg;
        soak_goal = SEC_W'(cur_entry_reg.minutes) * SEC_W'(SEC_PER_MIN);
    end

    // request decode and state update
    always_comb
    begin
        firing_next      = firing_reg;
        error_next       = error_reg;
        step_index_next  = step_index_reg;
        step_count_next  = step_count_reg;
        step_sec_next    = step_sec_reg;
        soak_sec_next    = soak_sec_reg;
        pause_next       = pause_reg;
        prev_target_next = prev_target_reg;
        mem_we           = 1'b0;
        do_adv           = 1'b0;
        mid_next         = '0;
        mid_next.held_op = HELD_KEEP;

        slot_ok = WIDE_W'(slot) < WIDE_W'(MAX_STEPS);

        if (in_fire)
        begin
            unique case (kind_t'(kind))
                KIND_TICK:
                begin
                    if (firing_reg && !sensor_ok)
                    begin
                        firing_next      = 1'b0;
                        error_next       = 1'b1;
                        step_sec_next    = '0;
                        soak_sec_next    = '0;
                        pause_next       = 1'b0;
                        mid_next.held_op = HELD_SET;
                    end
                    else if (firing_reg)
                    begin
                        step_sec_next = sec_inc;
                        if (cur_hold)
                        begin
                            pause_next        = pause_new;
                            soak_sec_next     = soak_inc;
                            mid_next.held_op  = HELD_SET;
                            mid_next.held_val = cur_entry_reg.target;
                            do_adv            = soak_inc >= soak_goal;
                        end
                        else if (crossed)
                        begin
                            mid_next.held_op  = HELD_SET;
                            mid_next.held_val = cur_entry_reg.target;
                            do_adv            = 1'b1;
                        end
                        else
                        begin
                            mid_next.held_op  = HELD_RAMP;
                            mid_next.ramp_neg = rate_eff[ERATE_W-1];
                            mid_next.ramp_mag = prod_abs[MAG_W-1:0];
                            soak_sec_next     = '0;
                            pause_next        = 1'b0;
                        end
                    end
                end
                KIND_LOAD:
                begin
                    if (slot_ok)
                    begin
                        mem_we = 1'b1;
                        // track the origin of the running ramp
                        if (WIDE_W'(slot) + 1'b1 == WIDE_W'(step_index_reg))
                        begin
                            prev_target_next = target_temp;
                        end
                    end
                    else
                    begin
                        mid_next.rejected = 1'b1;
                    end
                end
                KIND_START:
                begin
                    if (step_total == '0)
                    begin
                        mid_next.rejected = 1'b1;
                    end
                    else
                    begin
                        if (WIDE_W'(step_total) > WIDE_W'(MAX_STEPS))
                        begin
                            step_count_next = STEP_W'(MAX_STEPS);
                        end
                        else
                        begin
                            step_count_next = step_total;
                        end
                        step_index_next   = '0;
                        firing_next       = 1'b1;
                        error_next        = 1'b0;
                        step_sec_next     = '0;
                        soak_sec_next     = '0;
                        pause_next        = 1'b0;
                        mid_next.held_op  = HELD_SET;
                        mid_next.held_val = hold_bits_reg[0] ? slot0_target_reg
                                                             : first_start_reg;
                    end
                end
                KIND_STOP:
                begin
                    firing_next      = 1'b0;
                    error_next       = 1'b0;
                    step_sec_next    = '0;
                    soak_sec_next    = '0;
                    pause_next       = 1'b0;
                    mid_next.held_op = HELD_SET;
                end
                KIND_SKIP:
                begin
                    if (firing_reg)
                    begin
                        do_adv = 1'b1;
                    end
                    else
                    begin
                        mid_next.rejected = 1'b1;
                    end
                end
                default:
                begin
                    mid_next.rejected = 1'b1;
                end
            endcase

            if (do_adv)
            begin
                step_index_next  = step_index_reg + 1'b1;
                step_sec_next    = '0;
                soak_sec_next    = '0;
                pause_next       = 1'b0;
                prev_target_next = cur_entry_reg.target;
                if (step_index_next >= step_count_reg)
                begin
                    firing_next       = 1'b0;
                    mid_next.held_op  = HELD_SET;
                    mid_next.held_val = '0;
                    mid_next.finished = 1'b1;
                end
            end
        end

        slot_hits_next = mem_we && (WIDE_W'(slot) == WIDE_W'(step_index_next));
        new_hold       = slot_hits_next ? step_is_hold
                                        : hold_bits_reg[IDX_W'(step_index_next)];

        mid_next.ramp_start   = start_val;
        mid_next.firing       = firing_next;
        mid_next.current_step = step_index_next;
        mid_next.soak_paused  = firing_next && pause_next;
        if (firing_next)
        begin
            mid_next.status = new_hold ? STATUS_HOLD : STATUS_RAMP;
        end
        else
        begin
            mid_next.status = error_next ? STATUS_ERROR : STATUS_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            firing_reg      <= 1'b0;
            error_reg       <= 1'b0;
            step_index_reg  <= '0;
            step_count_reg  <= '0;
            step_sec_reg    <= '0;
            soak_sec_reg    <= '0;
            pause_reg       <= 1'b0;
            prev_target_reg <= '0;
        end
        else
        begin
            firing_reg      <= firing_next;
            error_reg       <= error_next;
            step_index_reg  <= step_index_next;
            step_count_reg  <= step_count_next;
            step_sec_reg    <= step_sec_next;
            soak_sec_reg    <= soak_sec_next;
            pause_reg       <= pause_next;
            prev_target_reg <= prev_target_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_start_reg <= FIRST_RAMP_START_RST;
            pause_thr_reg   <= PAUSE_THR_RST;
            resume_thr_reg  <= RESUME_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FIRST_RAMP_START: first_start_reg <= cfg_data;
                CFG_PAUSE_THR:        pause_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_RESUME_THR:       resume_thr_reg  <= cfg_data[THR_W-1:0];
                default:              ;
            endcase
        end
    end

    // step table: hold bits and slot 0 target in flops, the rest in memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hold_bits_reg[IDX_W'(slot)] <= step_is_hold;
            if (slot == '0)
            begin
                slot0_target_reg <= target_temp;
            end
        end
    end

    // registered read of the step that runs after this cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            step_mem[IDX_W'(slot)] <= load_entry;
        end
        if (slot_hits_next)
        begin
            cur_entry_reg <= load_entry;
        end
        else
        begin
            cur_entry_reg <= step_mem[IDX_W'(step_index_next)];
        end
    end

    `RSPS_ASSERT_IMPL(a_firing_no_error, firing_reg, !error_reg)
    `RSPS_ASSERT_IMPL(a_index_in_run, firing_reg, step_index_reg < step_count_reg)
    `RSPS_ASSERT_NEXT(a_finish_stops, in_fire && mid_next.finished, !firing_reg)
    `RSPS_ASSERT_NEXT(a_stop_idles, in_fire && kind == KIND_STOP, !firing_reg && !error_reg)

endmodule

### rtl/rsps_pipe.sv
module rsps_pipe
    import rsps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  mid_t              mid_in,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [TEMP_W-1:0] setpoint,
    output logic [STEP_W-1:0] current_step,
    output logic              finished,
    output logic              soak_paused,
    output logic              rejected
);

    localparam int QF_W = MAG_W + RECIP_W;

    logic              mid_valid_reg, mid_valid_next;
    mid_t              mid_reg;
    logic              out_valid_reg, out_valid_next;
    logic [TEMP_W-1:0] held_reg, held_next;
    logic              out_take;
    logic              mid_move;
    logic [QF_W-1:0]   q_full;
    logic [TEMP_W-1:0] quot;
    logic signed [TEMP_W+1:0] ramp_sum;
    logic [TEMP_W-1:0] ramp_val;

    logic [1:0]        status_reg;
    logic [TEMP_W-1:0] setpoint_reg;
    logic [STEP_W-1:0] current_step_reg;
    logic              finished_reg;
    logic              soak_paused_reg;
    logic              rejected_reg;

    assign out_take = !out_valid_reg || out_ready;
    assign mid_move = mid_valid_reg && out_take;
    assign in_ready = !mid_valid_reg || mid_move;

    // divide the ramp progress by 900 through the reciprocal
    always_comb
    begin
        q_full   = QF_W'(mid_reg.ramp_mag) * QF_W'(RECIP_K);
        quot     = q_full[RECIP_SHIFT +: TEMP_W];
        if (mid_reg.ramp_neg)
        begin
            ramp_sum = $signed({2'b00, mid_reg.ramp_start}) - $signed({2'b00, quot});
        end
        else
        begin
            ramp_sum = $signed({2'b00, mid_reg.ramp_start}) + $signed({2'b00, quot});
        end
        if (ramp_sum < 0)
        begin
            ramp_val = '0;
        end
        else if (ramp_sum > $signed({2'b00, SP_MAX}))
        begin
            ramp_val = SP_MAX;
        end
        else
        begin
            ramp_val = ramp_sum[TEMP_W-1:0];
        end

        case (mid_reg.held_op)
            HELD_SET:  held_next = mid_reg.held_val;
            HELD_RAMP: held_next = ramp_val;
            default:   held_next = held_reg;
        endcase
    end

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (in_fire)
        begin
            mid_valid_next = 1'b1;
        end
        else if (mid_move)
        begin
            mid_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (mid_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
            if (mid_move)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mid_reg <= mid_in;
        end
        if (mid_move)
        begin
            status_reg       <= mid_reg.status;
            setpoint_reg     <= mid_reg.firing ? held_next : '0;
            current_step_reg <= mid_reg.current_step;
            finished_reg     <= mid_reg.finished;
            soak_paused_reg  <= mid_reg.soak_paused;
            rejected_reg     <= mid_reg.rejected;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign setpoint     = setpoint_reg;
    assign current_step = current_step_reg;
    assign finished     = finished_reg;
    assign soak_paused  = soak_paused_reg;
    assign rejected     = rejected_reg;

endmodule

### rtl/ramp_soak_profile_sequencer.sv
// Ramp/soak setpoint programmer. Load requests fill a table of MAX_STEPS
// ramp or hold steps, a start request runs the first step_total of them, and
// each tick request stands for one second of the run and returns the setpoint
// in quarter degrees. Every request gives exactly one result. One request is
// taken each clock cycle while out_ready does not stall the pipeline; the
// first stage decodes the request, reads the current step from a registered
// step memory (addressed by the step index the request leaves behind) and
// forms rate*seconds in one 17x25 multiplier, and the second stage divides by
// 900 with a 23x24 reciprocal multiplier and registers the result. The result
// register lets a new request enter while the last result still waits on
// out_ready. A ramp reports start + rate*seconds/900 until it crosses its
// target; a hold reports its target, counts soak seconds only while the
// temperature is within the pause band, and ends after hold_minutes*60 soaked
// seconds. A tick with sensor_ok low during a run stops the run with error
// status until the next start or stop. Configuration writes are taken at any
// time through cfg_we; write them only while no request is in flight.
module ramp_soak_profile_sequencer
    import rsps_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic [TEMP_W-1:0]        measured_temp,
    input  logic                     sensor_ok,
    input  logic [SLOT_W-1:0]        slot,
    input  logic                     step_is_hold,
    input  logic signed [RATE_W-1:0] ramp_rate,
    input  logic [TEMP_W-1:0]        target_temp,
    input  logic [MIN_W-1:0]         hold_minutes,
    input  logic [STEP_W-1:0]        step_total,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [TEMP_W-1:0]        setpoint,
    output logic [STEP_W-1:0]        current_step,
    output logic                     finished,
    output logic                     soak_paused,
    output logic                     rejected
);

    logic in_fire;
    mid_t mid_next;

    // a request moves when the update stage has room
    assign in_fire = in_valid && in_ready;

    // decode, step table and run state
    rsps_exec #(
        .MAX_STEPS (MAX_STEPS)
    ) u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_fire       (in_fire),
        .kind          (kind),
        .measured_temp (measured_temp),
        .sensor_ok     (sensor_ok),
        .slot          (slot),
        .step_is_hold  (step_is_hold),
        .ramp_rate     (ramp_rate),
        .target_temp   (target_temp),
        .hold_minutes  (hold_minutes),
        .step_total    (step_total),
        .mid_next      (mid_next)
    );

    // hold the setpoint, scale the ramp and drive the result register
    rsps_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .mid_in       (mid_next),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .setpoint     (setpoint),
        .current_step (current_step),
        .finished     (finished),
        .soak_paused  (soak_paused),
        .rejected     (rejected)
    );

endmodule

### tb/sv/ramp_soak_profile_sequencer_test.sv
`timescale 1ns / 1ps

module ramp_soak_profile_sequencer_test;
    import rsps_pkg::*;

    // Own copies of the program arithmetic constants.
    localparam int NSTEPS            = MAX_STEPS_DEF;
    localparam int RAMP_DIVISOR      = 900;
    localparam int SLOW_RATE_CAP     = 9999;
    localparam int FAST_DEG_PER_HOUR = 60000;
    localparam int SECS_PER_MINUTE   = 60;
    localparam int COUNT_CEIL        = 16777215;
    localparam int TEMP_CEIL         = 8191;

    // Request kinds the block must reject as unknown.
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    localparam int ITEMS_TARGET    = 1400;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic [TEMP_W-1:0]        temp;
        logic                     ok;
        logic [SLOT_W-1:0]        slot;
        logic                     hold;
        logic signed [RATE_W-1:0] rate;
        logic [TEMP_W-1:0]        target;
        logic [MIN_W-1:0]         minutes;
        logic [STEP_W-1:0]        total;
    } request_t;

    typedef struct {
        status_t           status;
        logic [TEMP_W-1:0] setpoint;
        logic [STEP_W-1:0] step;
        logic              finished;
        logic              paused;
        logic              rejected;
    } report_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind = '0;
    logic [TEMP_W-1:0]        measured_temp = '0;
    logic                     sensor_ok = 1'b0;
    logic [SLOT_W-1:0]        slot = '0;
    logic                     step_is_hold = 1'b0;
    logic signed [RATE_W-1:0] ramp_rate = '0;
    logic [TEMP_W-1:0]        target_temp = '0;
    logic [MIN_W-1:0]         hold_minutes = '0;
    logic [STEP_W-1:0]        step_total = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic [TEMP_W-1:0]        setpoint;
    logic [STEP_W-1:0]        current_step;
    logic                     finished;
    logic                     soak_paused;
    logic                     rejected;

    ramp_soak_profile_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .measured_temp (measured_temp),
        .sensor_ok     (sensor_ok),
        .slot          (slot),
        .step_is_hold  (step_is_hold),
        .ramp_rate     (ramp_rate),
        .target_temp   (target_temp),
        .hold_minutes  (hold_minutes),
        .step_total    (step_total),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .setpoint      (setpoint),
        .current_step  (current_step),
        .finished      (finished),
        .soak_paused   (soak_paused),
        .rejected      (rejected)
    );

    always #5 clk = ~clk;

    // Program state mirrored by the predictor: step table, registers, run.
    bit prog_hold    [NSTEPS];
    int prog_rate    [NSTEPS];
    int prog_target  [NSTEPS];
    int prog_minutes [NSTEPS];

    int ramp_start_cfg = int'(FIRST_RAMP_START_RST);
    int pause_cfg      = int'(PAUSE_THR_RST);
    int resume_cfg     = int'(RESUME_THR_RST);

    bit run_active;
    bit run_fault;
    bit soak_hold;
    bit run_done;
    int cur_step;
    int run_steps;
    int step_secs;
    int soak_secs;
    int sp_now;

    // Reports owed by the block, oldest first.
    report_t report_q[$];

    int  mismatch_count;
    int  items_sent;
    int  burst_left;
    bit  sender_gaps_on = 1'b1;
    bit  long_stall_pending;
    int  quiet_cycles;

    function automatic int clip_temp(longint v);
        if (v < 0) return 0;
        if (v > TEMP_CEIL) return TEMP_CEIL;
        return int'(v);
    endfunction

    function automatic void clear_step_state();
        step_secs = 0;
        soak_secs = 0;
        soak_hold = 1'b0;
    endfunction

    // Move to the next step; running off the end finishes the program.
    function automatic void next_step();
        cur_step++;
        clear_step_state();
        if (cur_step >= run_steps) begin
            run_active = 1'b0;
            sp_now     = 0;
            run_done   = 1'b1;
        end
    endfunction

    // One second of the running program with a valid reading.
    function automatic void tick_program(int temp);
        int     dev;
        int     origin;
        longint rate;
        longint travel;
        longint lhs;
        longint rhs;
        bit     crossed;
        if (step_secs < COUNT_CEIL) step_secs++;
        if (prog_hold[cur_step]) begin
            // Pause/resume first, then count an unpaused soak second.
            dev = prog_target[cur_step] - temp;
            if (dev > pause_cfg) soak_hold = 1'b1;
            else if (dev <= resume_cfg) soak_hold = 1'b0;
            if (!soak_hold && soak_secs < COUNT_CEIL) soak_secs++;
            sp_now = prog_target[cur_step];
            if (soak_secs >= prog_minutes[cur_step] * SECS_PER_MINUTE) next_step();
        end else begin
            origin = (cur_step == 0) ? ramp_start_cfg : prog_target[cur_step - 1];
            rate = (prog_rate[cur_step] == 0 || prog_rate[cur_step] >= SLOW_RATE_CAP) ?
                   FAST_DEG_PER_HOUR : prog_rate[cur_step];
            travel = rate * step_secs;
            // Exact crossing test, scaled by the divisor on both sides.
            lhs = longint'(origin) * RAMP_DIVISOR + travel;
            rhs = longint'(prog_target[cur_step]) * RAMP_DIVISOR;
            crossed = (rate > 0) ? (lhs >= rhs) : (lhs <= rhs);
            if (crossed) begin
                sp_now = clip_temp(prog_target[cur_step]);
                next_step();
            end else begin
                sp_now = clip_temp(origin + travel / RAMP_DIVISOR);
                soak_secs = 0;
                soak_hold = 1'b0;
            end
        end
    endfunction

    // Apply one accepted request to the mirrored program; return its report.
    function automatic report_t step_program(request_t r);
        report_t rep;
        int      total;
        run_done     = 1'b0;
        rep.rejected = 1'b0;
        case (r.kind)
            KIND_TICK: begin
                if (run_active) begin
                    if (!r.ok) begin
                        run_active = 1'b0;
                        run_fault  = 1'b1;
                        clear_step_state();
                        sp_now = 0;
                    end else begin
                        tick_program(int'(r.temp));
                    end
                end
            end
            KIND_LOAD: begin
                prog_hold[r.slot]    = r.hold;
                prog_rate[r.slot]    = int'(r.rate);
                prog_target[r.slot]  = int'(r.target);
                prog_minutes[r.slot] = int'(r.minutes);
            end
            KIND_START: begin
                total = int'(r.total);
                if (total == 0) begin
                    rep.rejected = 1'b1;
                end else begin
                    run_steps  = (total > NSTEPS) ? NSTEPS : total;
                    cur_step   = 0;
                    run_active = 1'b1;
                    run_fault  = 1'b0;
                    clear_step_state();
                    sp_now = prog_hold[0] ? prog_target[0] : clip_temp(ramp_start_cfg);
                end
            end
            KIND_STOP: begin
                run_active = 1'b0;
                run_fault  = 1'b0;
                clear_step_state();
                sp_now = 0;
            end
            KIND_SKIP: begin
                if (!run_active) rep.rejected = 1'b1;
                else next_step();
            end
            default: rep.rejected = 1'b1;
        endcase
        if (run_active) rep.status = prog_hold[cur_step] ? STATUS_HOLD : STATUS_RAMP;
        else rep.status = run_fault ? STATUS_ERROR : STATUS_IDLE;
        rep.setpoint = run_active ? sp_now[TEMP_W-1:0] : '0;
        rep.step     = cur_step[STEP_W-1:0];
        rep.finished = run_done;
        rep.paused   = run_active && soak_hold;
        return rep;
    endfunction

    // Every field random over its full width; callers override what matters.
    function automatic request_t random_request();
        request_t r;
        r.kind    = KIND_W'($urandom_range(0, 7));
        r.temp    = TEMP_W'($urandom_range(0, TEMP_CEIL));
        r.ok      = 1'($urandom_range(0, 1));
        r.slot    = SLOT_W'($urandom_range(0, NSTEPS - 1));
        r.hold    = 1'($urandom_range(0, 1));
        r.rate    = RATE_W'($urandom_range(0, 32767));
        r.target  = TEMP_W'($urandom_range(0, TEMP_CEIL));
        r.minutes = MIN_W'($urandom_range(0, 65535));
        r.total   = STEP_W'($urandom_range(0, 31));
        return r;
    endfunction

    // Offer one request, hold it until accepted, then predict its report.
    task automatic send_request(input request_t r);
        int      gap;
        report_t rep;
        gap = 0;
        if (sender_gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= r.kind;
        measured_temp <= r.temp;
        sensor_ok     <= r.ok;
        slot          <= r.slot;
        step_is_hold  <= r.hold;
        ramp_rate     <= r.rate;
        target_temp   <= r.target;
        hold_minutes  <= r.minutes;
        step_total    <= r.total;
        do @(posedge clk); while (!in_ready);
        rep = step_program(r);
        report_q = {report_q, rep};
        items_sent++;
    endtask

    task automatic send_kind(input logic [KIND_W-1:0] k);
        request_t r;
        r = random_request();
        r.kind = k;
        send_request(r);
    endtask

    task automatic send_tick(input int temp, input bit ok);
        request_t r;
        r = random_request();
        r.kind = KIND_TICK;
        r.temp = TEMP_W'(temp);
        r.ok   = ok;
        send_request(r);
    endtask

    task automatic send_start(input int total);
        request_t r;
        r = random_request();
        r.kind  = KIND_START;
        r.total = STEP_W'(total);
        send_request(r);
    endtask

    task automatic load_step(input int idx, input bit hold, input int rate,
                             input int target, input int minutes);
        request_t r;
        r = random_request();
        r.kind    = KIND_LOAD;
        r.slot    = SLOT_W'(idx);
        r.hold    = hold;
        r.rate    = RATE_W'(rate);
        r.target  = TEMP_W'(target);
        r.minutes = MIN_W'(minutes);
        send_request(r);
    endtask

    // Drop valid and wait until every owed report is back, plus pipeline slack.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (report_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FIRST_RAMP_START: ramp_start_cfg = value;
            CFG_PAUSE_THR:        pause_cfg = value;
            CFG_RESUME_THR:       resume_cfg = value;
            default: ;
        endcase
    endtask

    // Fill every slot so no step is ever run unwritten. The first six slots
    // set up the directed run below; the rest carry random field values.
    task automatic test_load_table();
        load_step(0, 1'b0, 0, 160, 65535);
        load_step(1, 1'b0, -9999, 150, 0);
        load_step(2, 1'b1, 0, 150, 0);
        load_step(3, 1'b0, 9999, 6000, 0);
        load_step(4, 1'b1, -1, 0, 65535);
        load_step(5, 1'b0, 1, TEMP_CEIL, 0);
        for (int i = 6; i < NSTEPS; i++)
            load_step(i, i[0], $urandom_range(0, 32767), $urandom_range(0, TEMP_CEIL),
                      $urandom_range(0, 65535));
    endtask

    // Commands with no run in progress: ignored or rejected.
    task automatic test_idle_commands();
        send_tick(3000, 1'b1);
        send_tick(3000, 1'b0);
        send_kind(KIND_SKIP);
        send_start(0);
        send_kind(KIND_UNUSED_LO);
        send_kind(KIND_UNUSED_HI);
        send_kind(KIND_STOP);
    endtask

    task automatic test_directed_run();
        send_start(31);             // saturate to the whole table
        send_tick(200, 1'b1);       // fast ramp crosses its target at once
        send_tick(150, 1'b1);       // falling ramp crosses on the first second
        send_tick(0, 1'b1);         // zero-minute hold ends even while paused
        send_tick(8191, 1'b1);      // fast climb toward 6000
        send_tick(6000, 1'b1);
        send_kind(KIND_SKIP);       // advance into the long hold
        send_tick(8191, 1'b1);      // above target: soak counts
        send_tick(100, 1'b0);       // sensor fault drops the run into error
        send_tick(100, 1'b1);       // ignored while in error
        send_kind(KIND_SKIP);       // rejected, nothing firing
        send_kind(KIND_STOP);       // clear the error
        send_start(2);
        send_tick(160, 1'b1);
        send_tick(150, 1'b1);       // last step done: finished
    endtask

    // Stall the receiver for a long stretch while requests keep coming,
    // so the block fills up and drops in_ready.
    task automatic test_receiver_hold_off();
        sender_gaps_on     = 1'b0;
        long_stall_pending = 1'b1;
        send_start(NSTEPS);
        for (int i = 0; i < 40; i++) send_tick(sp_now, 1'b1);
        sender_gaps_on = 1'b1;
    endtask

    // A short well-formed program with random content, then seconds of
    // operation around the setpoint with the odd skip, stop, fault or noise.
    task automatic run_profile();
        int n;
        int prev;
        int delta;
        int target;
        int rate;
        int minutes;
        int total;
        int ticks;
        int roll;
        int temp;
        int drop;
        bit hold;
        n    = $urandom_range(1, 4);
        prev = ramp_start_cfg;
        for (int i = 0; i < n; i++) begin
            hold    = ($urandom_range(0, 2) == 0);
            minutes = $urandom_range(0, 1);
            if (hold) begin
                delta  = $urandom_range(0, 40);
                target = clip_temp(prev + delta - 20);
                rate   = $urandom_range(0, 32767);
            end else begin
                delta  = $urandom_range(0, 160);
                target = clip_temp(prev + delta - 80);
                case ($urandom_range(0, 4))
                    0: rate = 0;
                    1: rate = SLOW_RATE_CAP;
                    2: rate = 16383;
                    default: begin
                        rate = $urandom_range(900, SLOW_RATE_CAP - 1);
                        if ($urandom_range(0, 1) == 1) rate = -rate;
                    end
                endcase
            end
            load_step(i, hold, rate, target, minutes);
            prev = target;
        end
        total = n;
        if ($urandom_range(0, 15) == 0) total = $urandom_range(n, 31);
        send_start(total);
        ticks = 0;
        while (run_active && ticks < 150) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                send_kind(KIND_STOP);
            end else if (roll < 5) begin
                send_kind(KIND_SKIP);
            end else if (roll < 6) begin
                send_tick($urandom_range(0, TEMP_CEIL), 1'b0);
            end else if (roll < 8) begin
                send_request(random_request());
            end else begin
                delta = $urandom_range(0, 30);
                temp  = sp_now + delta - 15;
                if ($urandom_range(0, 6) == 0) begin
                    drop = $urandom_range(0, 600);
                    temp = temp - drop;
                end
                send_tick(clip_temp(temp), 1'b1);
            end
            ticks++;
        end
    endtask

    // Several register settings, extremes among them, each with its own
    // share of random programs. Registers change only once drained.
    task automatic test_config_phases();
        int starts[6]  = '{0, 6000, 3000, 100, 6000, 0};
        int pauses[6]  = '{0, 400, 0, 12, 400, 0};
        int resumes[6] = '{0, 400, 400, 4, 0, 0};
        int goal;
        starts[5]  = $urandom_range(0, 6000);
        pauses[5]  = $urandom_range(0, 400);
        resumes[5] = $urandom_range(0, 400);
        for (int p = 0; p < 6; p++) begin
            drain();
            write_cfg(CFG_FIRST_RAMP_START, starts[p]);
            write_cfg(CFG_PAUSE_THR, pauses[p]);
            write_cfg(CFG_RESUME_THR, resumes[p]);
            goal = items_sent + (ITEMS_TARGET - items_sent) / (6 - p);
            while (items_sent < goal) run_profile();
        end
    endtask

    // Receiver: phases of steady, light and heavy stalling, plus the long
    // hold-off on request.
    initial begin
        int phase_left;
        int mode;
        phase_left = 0;
        mode       = 0;
        forever begin
            @(posedge clk);
            if (long_stall_pending) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                long_stall_pending = 1'b0;
            end
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 120);
            end
            phase_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check each report leaving the block against the oldest prediction.
    always @(posedge clk) begin
        report_t want;
        if (rst_n && out_valid && out_ready) begin
            if (report_q.size() == 0) begin
                $display("%0t: unexpected report: expected none, actual status %0d setpoint %0d",
                         $time, status, setpoint);
                mismatch_count++;
            end else begin
                want = report_q.pop_front();
                compare_field("status", 16'(want.status), 16'(status));
                compare_field("setpoint", 16'(want.setpoint), 16'(setpoint));
                compare_field("current_step", 16'(want.step), 16'(current_step));
                compare_field("finished", 16'(want.finished), 16'(finished));
                compare_field("soak_paused", 16'(want.paused), 16'(soak_paused));
                compare_field("rejected", 16'(want.rejected), 16'(rejected));
            end
        end
    end

    // Watchdog: too long with no handshake on either side ends the run.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ramp_soak_profile_sequencer test failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_table();
        test_idle_commands();
        test_directed_run();
        test_receiver_hold_off();
        test_config_phases();
        drain();
        if (mismatch_count == 0)
            $display("ramp_soak_profile_sequencer test passed");
        else
            $display("ramp_soak_profile_sequencer test failed");
        $finish;
    end

endmodule
